// ===== rtl/core/ctcg_pkg.sv =====
package ctcg_pkg;

  // Field and state widths
  localparam int unsigned LogitW     = 16;
  localparam int unsigned ClassW     = 8;
  localparam int unsigned CcW        = 9;
  localparam int unsigned CountW     = 11;
  localparam int unsigned ConfW      = 16;
  localparam int unsigned SumW       = 25;
  localparam int unsigned TotalW     = 27;
  localparam int unsigned ProdW      = SumW + ConfW;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 9;

  // Divider widths
  localparam int unsigned DivNumW    = 32;
  localparam int unsigned DivDenW    = 25;
  localparam int unsigned DivCntW    = $clog2(DivNumW);

  // Sizing
  localparam int unsigned MaxClasses = 256;
  localparam int unsigned MaxFrames  = 1024;
  localparam int unsigned CountCap   = (MaxFrames < 2047) ? MaxFrames : 2047;
  localparam int unsigned ExpDepth   = 256;
  localparam int unsigned ExpIdxW    = $clog2(ExpDepth);
  localparam int unsigned ExpShift   = 4;

  localparam logic [SumW-1:0]   SumMax   = '1;
  localparam logic [TotalW-1:0] TotalMax = '1;
  localparam logic [ConfW-1:0]  ConfMax  = '1;
  localparam logic [CcW-1:0]    NoneMark = CcW'(256);
  localparam logic signed [LogitW-1:0] LogitMin = {1'b1, {(LogitW-1){1'b0}}};

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgClassCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyCount   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBlankIndex = 2'd2;

  // Result kinds
  localparam logic KindToken   = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef logic [ExpDepth-1:0][ConfW-1:0] exp_tab_t;

  // exp(-i/16) in Q0.16, built at elaboration
  function automatic exp_tab_t exp_build();
    exp_tab_t    tab;
    logic [95:0] e;
    logic [95:0] t;
    e = 96'd1 << 32;
    for (int i = 0; i < ExpDepth; i++) begin
      t = (e + 96'd32768) >> 16;
      tab[i] = (t > 96'd65535) ? 16'hFFFF : t[15:0];
      e = (e * 96'd4034748383 + (96'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam exp_tab_t ExpTab = exp_build();

  // Divider handshake
  typedef struct packed {
    logic                start;
    logic [DivNumW-1:0]  num;
    logic [DivDenW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DivNumW-1:0]  quo;
  } div_rsp_t;

endpackage

// ===== rtl/core/ctc_greedy_decoder_with_confidence.sv =====
// Per logit: accept (StIdle), scale multiply (StMul), sum update (StAdd).
// Frame end: StFend, then for a token a division in the shared serial divider (StCdiv) and emit (StTok).
// Sequence end: StMstart and StSum, with a divider pass for the mean (StMdiv) when tokens exist.
// A new logit is taken only after the previous one is through (in_stall_o outside StIdle); output stalls add waits.
// Reset: asynchronous active low; clears sequence state, registers reset to
// class_count 2, emit limit 1, blank_index 255.
module ctc_greedy_decoder_with_confidence (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ctcg_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ctcg_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [ctcg_pkg::LogitW-1:0]  logit_i,
  input  logic                                last_in_frame_i,
  input  logic                                last_in_sequence_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                result_kind_o,
  output logic [ctcg_pkg::ClassW-1:0]         token_id_o,
  output logic [ctcg_pkg::ConfW-1:0]          token_confidence_o,
  output logic [ctcg_pkg::CountW-1:0]         seq_tokens_o,
  output logic [ctcg_pkg::ConfW-1:0]          mean_confidence_o,
  output logic [ctcg_pkg::CountW-1:0]         blank_win_count_o,
  output logic [ctcg_pkg::CountW-1:0]         frame_count_o,
  output logic                                last_o
);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StMul   = 9'b000000010,
    StAdd   = 9'b000000100,
    StFend  = 9'b000001000,
    StCdiv  = 9'b000010000,
    StTok   = 9'b000100000,
    StMstart= 9'b001000000,
    StMdiv  = 9'b010000000,
    StSum   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [ctcg_pkg::CcW-1:0]    class_count_q;
  logic [ctcg_pkg::ClassW-1:0] emit_limit_q, blank_index_q;

  // Captured item
  logic signed [ctcg_pkg::LogitW-1:0] v_q;
  logic                               eof_q, eos_q;

  // Frame and sequence state
  logic [ctcg_pkg::ClassW-1:0]        pos_q, pos_d;
  logic signed [ctcg_pkg::LogitW-1:0] max_q, max_d;
  logic [ctcg_pkg::ClassW-1:0]        win_q, win_d;
  logic [ctcg_pkg::SumW-1:0]          sum_q, sum_d;
  logic [ctcg_pkg::CcW-1:0]           prev_q, prev_d;
  logic [ctcg_pkg::CountW-1:0]        tok_q, tok_d, blanks_q, blanks_d, frames_q, frames_d;
  logic [ctcg_pkg::TotalW-1:0]        total_q, total_d;
  logic [ctcg_pkg::ConfW-1:0]         conf_q, conf_d;

  // Multiply stage
  logic [ctcg_pkg::ProdW-1:0] prod_q, prod_d;
  logic [ctcg_pkg::ConfW-1:0] e_q, e_d;
  logic                       up_q, up_d;

  // Output register
  logic                        ov_q, ov_d;
  logic                        okind_q, okind_d;
  logic [ctcg_pkg::ClassW-1:0] oid_q, oid_d;
  logic [ctcg_pkg::ConfW-1:0]  oconf_q, oconf_d, omean_q, omean_d;
  logic [ctcg_pkg::CountW-1:0] otok_q, otok_d, oblank_q, oblank_d, oframe_q, oframe_d;

  ctcg_pkg::div_req_t div_req;
  ctcg_pkg::div_rsp_t div_rsp;

  ctcg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Helper values
  logic                        up_now;
  logic [ctcg_pkg::LogitW-1:0] diff;
  logic [ctcg_pkg::LogitW-ctcg_pkg::ExpShift-1:0] eidx;
  logic [ctcg_pkg::ConfW-1:0]  e_now;
  logic [ctcg_pkg::CcW-1:0]    cc, blank;
  logic [ctcg_pkg::ProdW:0]    rnd;
  logic [ctcg_pkg::SumW+1:0]   s_up;
  logic [ctcg_pkg::SumW:0]     s_add;
  logic                        slot_free;
  logic [ctcg_pkg::ConfW-1:0]  q_sat;
  logic [ctcg_pkg::TotalW:0]   tot_sum;

  always_comb begin
    up_now = (pos_q == '0) || (v_q > max_q);
    diff   = up_now ? ctcg_pkg::LogitW'(v_q - max_q) : ctcg_pkg::LogitW'(max_q - v_q);
    eidx   = diff[ctcg_pkg::LogitW-1:ctcg_pkg::ExpShift];
    e_now  = (eidx < ($bits(eidx))'(ctcg_pkg::ExpDepth))
             ? ctcg_pkg::ExpTab[eidx[ctcg_pkg::ExpIdxW-1:0]] : '0;

    // effective class count and blank class
    if (class_count_q < ctcg_pkg::CcW'(2)) begin
      cc = ctcg_pkg::CcW'(2);
    end else if (class_count_q > ctcg_pkg::CcW'(ctcg_pkg::MaxClasses)) begin
      cc = ctcg_pkg::CcW'(ctcg_pkg::MaxClasses);
    end else begin
      cc = class_count_q;
    end
    if ({1'b0, blank_index_q} < cc) begin
      blank = {1'b0, blank_index_q};
    end else if (cc == {1'b0, emit_limit_q} + 1'b1) begin
      blank = {1'b0, emit_limit_q};
    end else begin
      blank = cc - 1'b1;
    end

    rnd   = {1'b0, prod_q} + (ctcg_pkg::ProdW + 1)'(32768);
    s_up  = ((pos_q != '0) ? (ctcg_pkg::SumW + 2)'(rnd >> 16) : '0)
            + (ctcg_pkg::SumW + 2)'(ctcg_pkg::ExpTab[0]);
    s_add = {1'b0, sum_q} + (ctcg_pkg::SumW + 1)'(e_q);

    slot_free = !ov_q || !out_stall_i;
    q_sat     = (div_rsp.quo > ctcg_pkg::DivNumW'(ctcg_pkg::ConfMax))
                ? ctcg_pkg::ConfMax : div_rsp.quo[ctcg_pkg::ConfW-1:0];
    tot_sum   = {1'b0, total_q} + (ctcg_pkg::TotalW + 1)'(conf_q);
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    max_d    = max_q;
    win_d    = win_q;
    sum_d    = sum_q;
    prev_d   = prev_q;
    tok_d    = tok_q;
    blanks_d = blanks_q;
    frames_d = frames_q;
    total_d  = total_q;
    conf_d   = conf_q;
    prod_d   = prod_q;
    e_d      = e_q;
    up_d     = up_q;
    ov_d     = ov_q && out_stall_i;
    okind_d  = okind_q;
    oid_d    = oid_q;
    oconf_d  = oconf_q;
    omean_d  = omean_q;
    otok_d   = otok_q;
    oblank_d = oblank_q;
    oframe_d = oframe_q;
    div_req  = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StMul;
      end
      StMul: begin
        up_d    = up_now;
        e_d     = e_now;
        prod_d  = ctcg_pkg::ProdW'(sum_q) * ctcg_pkg::ProdW'(e_now);
        state_d = StAdd;
      end
      StAdd: begin
        if (up_q) begin
          sum_d = (s_up > (ctcg_pkg::SumW + 2)'(ctcg_pkg::SumMax))
                  ? ctcg_pkg::SumMax : s_up[ctcg_pkg::SumW-1:0];
          max_d = v_q;
          win_d = pos_q;
        end else begin
          sum_d = s_add[ctcg_pkg::SumW] ? ctcg_pkg::SumMax : s_add[ctcg_pkg::SumW-1:0];
        end
        if (!eof_q && !eos_q && ({1'b0, pos_q} + 1'b1 < cc)) begin
          pos_d   = pos_q + 1'b1;
          state_d = StIdle;
        end else begin
          state_d = StFend;
        end
      end
      StFend: begin
        if (frames_q < ctcg_pkg::CountW'(ctcg_pkg::CountCap)) frames_d = frames_q + 1'b1;
        state_d = eos_q ? StMstart : StIdle;
        if ({1'b0, win_q} == blank) begin
          if (blanks_q < ctcg_pkg::CountW'(ctcg_pkg::CountCap)) blanks_d = blanks_q + 1'b1;
        end else if (({1'b0, win_q} != prev_q) && (win_q < emit_limit_q)) begin
          div_req.start = 1'b1;
          div_req.num   = {ctcg_pkg::ExpTab[0], 16'd0};
          div_req.den   = sum_q;
          state_d       = StCdiv;
        end
        prev_d = {1'b0, win_q};
        pos_d  = '0;
        max_d  = ctcg_pkg::LogitMin;
        win_d  = '0;
        sum_d  = '0;
      end
      StCdiv: begin
        if (div_rsp.done) begin
          conf_d  = q_sat;
          state_d = StTok;
        end
      end
      StTok: begin
        if (slot_free) begin
          ov_d     = 1'b1;
          okind_d  = ctcg_pkg::KindToken;
          oid_d    = prev_q[ctcg_pkg::ClassW-1:0];
          oconf_d  = conf_q;
          omean_d  = '0;
          otok_d   = '0;
          oblank_d = '0;
          oframe_d = '0;
          if (tok_q < ctcg_pkg::CountW'(ctcg_pkg::CountCap)) begin
            tok_d   = tok_q + 1'b1;
            total_d = tot_sum[ctcg_pkg::TotalW] ? ctcg_pkg::TotalMax
                                                : tot_sum[ctcg_pkg::TotalW-1:0];
          end
          state_d = eos_q ? StMstart : StIdle;
        end
      end
      StMstart: begin
        if (tok_q == '0) begin
          conf_d  = '0;
          state_d = StSum;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = ctcg_pkg::DivNumW'(total_q);
          div_req.den   = ctcg_pkg::DivDenW'(tok_q);
          state_d       = StMdiv;
        end
      end
      StMdiv: begin
        if (div_rsp.done) begin
          conf_d  = q_sat;
          state_d = StSum;
        end
      end
      StSum: begin
        if (slot_free) begin
          ov_d     = 1'b1;
          okind_d  = ctcg_pkg::KindSummary;
          oid_d    = '0;
          oconf_d  = '0;
          omean_d  = conf_q;
          otok_d   = tok_q;
          oblank_d = blanks_q;
          oframe_d = frames_q;
          // sequence restart
          prev_d   = ctcg_pkg::NoneMark;
          tok_d    = '0;
          total_d  = '0;
          blanks_d = '0;
          frames_d = '0;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control and sequence registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      class_count_q <= ctcg_pkg::CcW'(2);
      emit_limit_q  <= ctcg_pkg::ClassW'(1);
      blank_index_q <= ctcg_pkg::ClassW'(255);
      pos_q         <= '0;
      max_q         <= ctcg_pkg::LogitMin;
      win_q         <= '0;
      sum_q         <= '0;
      prev_q        <= ctcg_pkg::NoneMark;
      tok_q         <= '0;
      total_q       <= '0;
      blanks_q      <= '0;
      frames_q      <= '0;
      ov_q          <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      max_q    <= max_d;
      win_q    <= win_d;
      sum_q    <= sum_d;
      prev_q   <= prev_d;
      tok_q    <= tok_d;
      total_q  <= total_d;
      blanks_q <= blanks_d;
      frames_q <= frames_d;
      ov_q     <= ov_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ctcg_pkg::CfgClassCount: class_count_q <= cfg_data_i;
          ctcg_pkg::CfgKeyCount:   emit_limit_q  <= cfg_data_i[ctcg_pkg::ClassW-1:0];
          ctcg_pkg::CfgBlankIndex: blank_index_q <= cfg_data_i[ctcg_pkg::ClassW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      v_q   <= logit_i;
      eof_q <= last_in_frame_i;
      eos_q <= last_in_sequence_i;
    end
    prod_q   <= prod_d;
    e_q      <= e_d;
    up_q     <= up_d;
    conf_q   <= conf_d;
    okind_q  <= okind_d;
    oid_q    <= oid_d;
    oconf_q  <= oconf_d;
    omean_q  <= omean_d;
    otok_q   <= otok_d;
    oblank_q <= oblank_d;
    oframe_q <= oframe_d;
  end

  assign cfg_ready_o        = 1'b1;
  assign in_stall_o         = (state_q != StIdle);
  assign out_valid_o        = ov_q;
  assign result_kind_o      = okind_q;
  assign token_id_o         = oid_q;
  assign token_confidence_o = oconf_q;
  assign seq_tokens_o       = otok_q;
  assign mean_confidence_o  = omean_q;
  assign blank_win_count_o  = oblank_q;
  assign frame_count_o      = oframe_q;
  assign last_o             = okind_q;

  // Checks
  a_token_below_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == ctcg_pkg::KindToken) |-> (token_id_o < emit_limit_q))
    else $error("token id not below emit limit");

  a_blanks_le_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == ctcg_pkg::KindSummary) |->
      (blank_win_count_o <= frame_count_o && seq_tokens_o <= frame_count_o))
    else $error("summary counts exceed frame count");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> !div_rsp.done)
    else $error("divider done right after start");

  a_sum_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFend) |-> (sum_q >= ctcg_pkg::SumW'(ctcg_pkg::ExpTab[0])))
    else $error("softmax sum below one at frame end");

endmodule

// ===== rtl/core/ctcg_div.sv =====
// Restoring divider, one quotient bit per cycle
module ctcg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctcg_pkg::div_req_t req_i,
  output ctcg_pkg::div_rsp_t rsp_o
);

  logic [ctcg_pkg::DivNumW-1:0] quo_q, quo_d;
  logic [ctcg_pkg::DivDenW:0]   rem_q, rem_d;
  logic [ctcg_pkg::DivDenW-1:0] den_q, den_d;
  logic [ctcg_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [ctcg_pkg::DivDenW+1:0] trial;
  logic [ctcg_pkg::DivDenW:0]   shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[ctcg_pkg::DivDenW-1:0], quo_q[ctcg_pkg::DivNumW-1]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in next dividend bit, subtract if it fits
      if (!trial[ctcg_pkg::DivDenW+1]) begin
        rem_d = trial[ctcg_pkg::DivDenW:0];
        quo_d = {quo_q[ctcg_pkg::DivNumW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[ctcg_pkg::DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ctcg_pkg::DivCntW'(ctcg_pkg::DivNumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule
